@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the trilateration RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every edge out of reset
`define WAT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be seen out of reset
`define WAT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`endif

@@ hw/rtl/wat_pkg.sv @@
// Shared types and constants of the wall anchor trilateration block.
// No dependencies.
`default_nettype none
package wat_pkg;
  localparam int STORE_DEPTH = 4;
  localparam int RANGE_W     = 16;
  localparam int POS_W       = 18;
  localparam int ARG_W       = 35;
  localparam int DVS_W       = 17;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_COUNT   = 2'd1,
    ST_NO_PAIR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_POS0   = 3'd0,
    REG_POS1   = 3'd1,
    REG_POS2   = 3'd2,
    REG_POS3   = 3'd3,
    REG_OFFSET = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [STORE_DEPTH-1:0][RANGE_W-1:0] ranges;
    logic [RANGE_W-1:0]                  wall;
    logic [RANGE_W-1:0]                  alt;
    logic                                cnt_err;
  } job_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;
endpackage
`default_nettype wire

@@ hw/rtl/wall_anchor_trilateration_unit.sv @@
// Top level of the wall anchor trilateration block: config registers,
// front end, scan queue and pair solver. Depends on wat_pkg and all wat_* modules.
//
// Usage:
//  - Input: one range beat per anchor, in anchor order, taken at an edge with
//    start high and busy low; in_last marks the final range of a scan, and
//    wall distance and altitude are sampled with that beat.
//  - Non-final beats are absorbed into the range store. A final beat queues the
//    scan; up to two scans wait while the solver works, busy is high while
//    both queue slots are full.
//  - Output: one result per scan, out_valid high for one cycle. There is no
//    backpressure, the receiver must take the beat in that cycle.
//  - After the final beat, a count error is reported without solving any
//    pair; else each solved pair uses a divide in the shared divide/root
//    unit, and the close-out uses two divides and a root.
//  - Config: cfg_valid/cfg_ready write channel, always ready; unknown
//    indexes are dropped. Write only while no scan is in flight.
//  - Reset (rst_n low, synchronous) clears the scan counters, queue, solver
//    and registers (anchor positions 0, wall offset 1000 mm).
`default_nettype none
module wall_anchor_trilateration_unit #(
  parameter int ANCHORS        = 4,
  parameter int MIN_SPACING_MM = 1000
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [15:0]                       in_range_mm,
  input  wire logic                              in_last,
  input  wire logic [15:0]                       in_wall_distance_mm,
  input  wire logic [15:0]                       in_altitude_mm,
  output logic                                   out_valid,
  output logic signed [wat_pkg::POS_W-1:0]       out_position_mm,
  output logic [15:0]                            out_divergence_mm,
  output logic [1:0]                             out_status,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [15:0]                       cfg_data
);
  logic [wat_pkg::STORE_DEPTH-1:0][15:0] anchor_pos_r;
  logic [15:0]   wall_offset_r;
  logic          q_full, q_push, q_pop, q_valid;
  wat_pkg::job_t push_job, head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_pos_r  <= '0;
      wall_offset_r <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wat_pkg::REG_POS0:   anchor_pos_r[0] <= cfg_data;
        wat_pkg::REG_POS1:   anchor_pos_r[1] <= cfg_data;
        wat_pkg::REG_POS2:   anchor_pos_r[2] <= cfg_data;
        wat_pkg::REG_POS3:   anchor_pos_r[3] <= cfg_data;
        wat_pkg::REG_OFFSET: wall_offset_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  wat_front #(.ANCHORS(ANCHORS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_range_mm        (in_range_mm),
    .in_last            (in_last),
    .in_wall_distance_mm(in_wall_distance_mm),
    .in_altitude_mm     (in_altitude_mm),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_job              (push_job)
  );

  wat_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .not_empty(q_valid),
    .full     (q_full)
  );

  wat_back #(
    .ANCHORS       (ANCHORS),
    .MIN_SPACING_MM(MIN_SPACING_MM)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_job         (head_job),
    .job_valid        (q_valid),
    .pop              (q_pop),
    .anchor_pos       (anchor_pos_r),
    .wall_offset      (wall_offset_r),
    .out_valid        (out_valid),
    .out_position_mm  (out_position_mm),
    .out_divergence_mm(out_divergence_mm),
    .out_status       (out_status)
  );
endmodule
`default_nettype wire

@@ hw/rtl/wat_front.sv @@
// Front end: collects the ranges of one scan and hands a finished scan on.
// Depends on wat_pkg.
`default_nettype none
module wat_front #(
  parameter int ANCHORS = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [wat_pkg::RANGE_W-1:0]  in_range_mm,
  input  wire logic                         in_last,
  input  wire logic [wat_pkg::RANGE_W-1:0]  in_wall_distance_mm,
  input  wire logic [wat_pkg::RANGE_W-1:0]  in_altitude_mm,
  input  wire logic                         q_full,
  output logic                              q_push,
  output wat_pkg::job_t                     q_job
);
  logic [wat_pkg::RANGE_W-1:0] store_r [wat_pkg::STORE_DEPTH];
  logic [2:0] cnt_r, cnt_nxt;
  logic       ovf_r, ovf_nxt;
  logic       accept, store_full;
  logic [2:0] n_scan;

  always_comb begin
    busy       = q_full;
    accept     = start && !q_full;
    store_full = cnt_r[2];
    n_scan     = store_full ? cnt_r : cnt_r + 3'd1;
    for (int k = 0; k < wat_pkg::STORE_DEPTH; k++) begin
      q_job.ranges[k] = (cnt_r == 3'(k)) ? in_range_mm : store_r[k];
    end
    q_job.wall    = in_wall_distance_mm;
    q_job.alt     = in_altitude_mm;
    q_job.cnt_err = ovf_r || store_full || (n_scan != 3'(ANCHORS));
    q_push        = accept && in_last;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    if (accept) begin
      if (in_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        cnt_nxt = n_scan;
        ovf_nxt = ovf_r || store_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !store_full) begin
      store_r[cnt_r[1:0]] <= in_range_mm;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/wat_fifo.sv @@
// Two-entry scan queue between front end and pair solver.
// Depends on wat_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wat_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wat_pkg::job_t      push_job,
  input  wire logic          pop,
  output wat_pkg::job_t      head_job,
  output logic               not_empty,
  output logic               full
);
  wat_pkg::job_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_comb begin
    head_job  = mem_r[rd_ptr_r];
    not_empty = (cnt_r != 2'd0);
    full      = (cnt_r == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      priority if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push)     cnt_r <= cnt_r - 2'd1;
      else                       cnt_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  `WAT_NEVER(a_no_push_full, clk, rst_n, push && full)
  `WAT_NEVER(a_no_pop_empty, clk, rst_n, pop && !not_empty)
  `WAT_NEVER(a_cnt_range, clk, rst_n, cnt_r == 2'd3)
endmodule
`default_nettype wire

@@ hw/rtl/wat_divsqrt.sv @@
// Shared iterative unit: restoring divide or floored square root, one bit a cycle.
// Depends on wat_pkg.
`default_nettype none
module wat_divsqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wat_pkg::ds_req_t                 req,
  input  wire logic [wat_pkg::ARG_W-1:0]   arg,
  input  wire logic [wat_pkg::DVS_W-1:0]   dvs,
  output logic                             done,
  output logic [wat_pkg::ARG_W-1:0]        res
);
  localparam int AW         = wat_pkg::ARG_W;
  localparam int DW         = wat_pkg::DVS_W;
  localparam int SW         = AW + 1;
  localparam int SQRT_STEPS = SW / 2;

  logic          busy_r, sqrt_r, done_r;
  logic [5:0]    cnt_r;
  logic [AW-1:0] quo_r;
  logic [DW-1:0] rem_r, dvs_r;
  logic [SW-1:0] v_r, root_r, bit_r;
  logic [DW:0]   trial;
  logic [SW-1:0] rsum;

  always_comb begin
    trial = {rem_r, quo_r[AW-1]};
    rsum  = root_r + bit_r;
    done  = done_r;
    res   = sqrt_r ? root_r[AW-1:0] : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sqrt_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        sqrt_r <= req.is_sqrt;
        cnt_r  <= req.is_sqrt ? 6'(SQRT_STEPS) : 6'(AW);
        quo_r  <= arg;
        rem_r  <= '0;
        dvs_r  <= dvs;
        v_r    <= SW'(arg);
        root_r <= '0;
        bit_r  <= SW'(1) << (SW - 2);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        if (sqrt_r) begin
          if (v_r >= rsum) begin
            v_r    <= v_r - rsum;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          if (trial >= {1'b0, dvs_r}) begin
            rem_r <= DW'(trial - {1'b0, dvs_r});
            quo_r <= {quo_r[AW-2:0], 1'b1};
          end else begin
            rem_r <= trial[DW-1:0];
            quo_r <= {quo_r[AW-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/wat_back.sv @@
// Back end: walks the anchor pairs of one scan and forms position and divergence.
// Depends on wat_pkg, wat_divsqrt and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wat_back #(
  parameter int ANCHORS        = 4,
  parameter int MIN_SPACING_MM = 1000
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wat_pkg::job_t                              head_job,
  input  wire logic                                  job_valid,
  output logic                                       pop,
  input  wire logic [wat_pkg::STORE_DEPTH-1:0][15:0] anchor_pos,
  input  wire logic [15:0]                           wall_offset,
  output logic                                       out_valid,
  output logic signed [wat_pkg::POS_W-1:0]           out_position_mm,
  output logic [15:0]                                out_divergence_mm,
  output logic [1:0]                                 out_status
);
  localparam int AW = wat_pkg::ARG_W;
  localparam logic [1:0]  LAST_I = 2'(ANCHORS - 2);
  localparam logic [1:0]  LAST_J = 2'(ANCHORS - 1);
  localparam logic [15:0] MIN_SP = 16'(MIN_SPACING_MM);

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_MUL_A, S_MUL_C, S_MUL_B, S_SUB, S_DIVQ, S_WAITQ,
    S_MULQ, S_ACC, S_NEXT, S_DIVP, S_WAITP, S_DIVH, S_WAITH, S_MULF,
    S_DIFF, S_SQRT, S_WAITS, S_OUT
  } state_t;

  state_t           state_r;
  wat_pkg::job_t    job_r;
  wat_pkg::status_t status_r;
  logic [1:0]       i_r, j_r;
  logic [31:0]      prod_r, aa_r;
  logic signed [AW-1:0] s_r;
  logic [15:0]      q_r;
  logic [20:0]      pos_sum_r;
  logic [AW-1:0]    hsq_sum_r, hmean_r;
  logic [2:0]       pairs_r;
  logic [17:0]      pos_r;
  logic             out_valid_r;
  logic [17:0]      out_pos_r;
  logic [15:0]      out_div_r;
  logic [1:0]       out_status_r;

  logic [15:0] a, b, pi, pj, c, fmag, mx, my;
  logic [31:0] prod;
  logic        skip, s_neg, p_neg, last_pair;
  logic [AW-1:0] smag;
  logic [20:0] pmag, term;
  logic [18:0] gap;
  logic [17:0] gap_mag;
  wat_pkg::ds_req_t ds_req;
  logic [AW-1:0] ds_arg, ds_res;
  logic [wat_pkg::DVS_W-1:0] ds_dvs;
  logic ds_done;

  always_comb begin
    a     = job_r.ranges[i_r];
    b     = job_r.ranges[j_r];
    pi    = anchor_pos[i_r];
    pj    = anchor_pos[j_r];
    c     = (pi >= pj) ? pi - pj : pj - pi;
    skip  = (a == 16'd0) || (b == 16'd0) || (c < MIN_SP) ||
            ({1'b0, a} + {1'b0, c} < {1'b0, b}) ||
            ({1'b0, b} + {1'b0, c} < {1'b0, a}) ||
            ({1'b0, a} + {1'b0, b} < {1'b0, c});
    s_neg = s_r[AW-1];
    smag  = s_neg ? AW'(-s_r) : AW'(s_r);
    p_neg = pos_sum_r[20];
    pmag  = p_neg ? -pos_sum_r : pos_sum_r;
    term  = s_neg ? 21'(pi) - 21'(q_r) : 21'(pi) + 21'(q_r);
    fmag  = (job_r.wall >= wall_offset) ? job_r.wall - wall_offset
                                        : wall_offset - job_r.wall;
    last_pair = (i_r == LAST_I) && (j_r == LAST_J);
    gap     = {1'b0, ds_res[17:0]} - 19'(job_r.alt);
    gap_mag = gap[18] ? 18'(-gap) : gap[17:0];
    pop     = (state_r == S_IDLE) && job_valid;

    mx = '0;
    my = '0;
    unique case (state_r)
      S_MUL_A: begin mx = a;    my = a;    end
      S_MUL_C: begin mx = c;    my = c;    end
      S_MUL_B: begin mx = b;    my = b;    end
      S_MULQ:  begin mx = q_r;  my = q_r;  end
      S_MULF:  begin mx = fmag; my = fmag; end
      default: begin mx = '0;   my = '0;   end
    endcase
    prod = {16'd0, mx} * {16'd0, my};

    ds_req.start   = 1'b0;
    ds_req.is_sqrt = 1'b0;
    ds_arg         = '0;
    ds_dvs         = '0;
    unique case (state_r)
      S_DIVQ: begin
        ds_req.start = 1'b1;
        ds_arg       = smag;
        ds_dvs       = {1'b0, c} << 1;
      end
      S_DIVP: begin
        ds_req.start = 1'b1;
        ds_arg       = AW'(pmag);
        ds_dvs       = 17'(pairs_r);
      end
      S_DIVH: begin
        ds_req.start = 1'b1;
        ds_arg       = hsq_sum_r;
        ds_dvs       = 17'(pairs_r);
      end
      S_SQRT: begin
        ds_req.start   = 1'b1;
        ds_req.is_sqrt = 1'b1;
        ds_arg         = hmean_r;
      end
      default: ;
    endcase

    out_valid         = out_valid_r;
    out_position_mm   = $signed(out_pos_r);
    out_divergence_mm = out_div_r;
    out_status        = out_status_r;
  end

  wat_divsqrt u_divsqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ds_req),
    .arg  (ds_arg),
    .dvs  (ds_dvs),
    .done (ds_done),
    .res  (ds_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pairs_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      prod_r      <= prod;
      unique case (state_r)
        S_IDLE: if (job_valid) begin
          job_r     <= head_job;
          i_r       <= 2'd0;
          j_r       <= 2'd1;
          pos_sum_r <= '0;
          hsq_sum_r <= '0;
          pairs_r   <= '0;
          status_r  <= wat_pkg::ST_COUNT;
          state_r   <= head_job.cnt_err ? S_OUT : S_SETUP;
        end
        S_SETUP: state_r <= skip ? S_NEXT : S_MUL_A;
        S_MUL_A: state_r <= S_MUL_C;
        S_MUL_C: begin
          aa_r    <= prod_r;
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          s_r     <= $signed({3'b0, aa_r}) + $signed({3'b0, prod_r});
          state_r <= S_SUB;
        end
        S_SUB: begin
          s_r     <= s_r - $signed({3'b0, prod_r});
          state_r <= S_DIVQ;
        end
        S_DIVQ: state_r <= S_WAITQ;
        S_WAITQ: if (ds_done) begin
          q_r     <= (ds_res > AW'(a)) ? a : ds_res[15:0];
          state_r <= S_MULQ;
        end
        S_MULQ: state_r <= S_ACC;
        S_ACC: begin
          hsq_sum_r <= hsq_sum_r + AW'(aa_r - prod_r);
          pos_sum_r <= pos_sum_r + term;
          pairs_r   <= pairs_r + 3'd1;
          state_r   <= S_NEXT;
        end
        S_NEXT: begin
          if (last_pair) begin
            status_r <= wat_pkg::ST_NO_PAIR;
            state_r  <= (pairs_r == 3'd0) ? S_OUT : S_DIVP;
          end else begin
            if (j_r == LAST_J) begin
              i_r <= i_r + 2'd1;
              j_r <= i_r + 2'd2;
            end else begin
              j_r <= j_r + 2'd1;
            end
            state_r <= S_SETUP;
          end
        end
        S_DIVP: state_r <= S_WAITP;
        S_WAITP: if (ds_done) begin
          pos_r   <= p_neg ? -ds_res[17:0] : ds_res[17:0];
          state_r <= S_DIVH;
        end
        S_DIVH: state_r <= S_WAITH;
        S_WAITH: if (ds_done) begin
          hmean_r <= ds_res;
          state_r <= S_MULF;
        end
        S_MULF: state_r <= S_DIFF;
        S_DIFF: begin
          // hmean_r now carries |hmean - flr^2|
          hmean_r <= (hmean_r >= AW'(prod_r)) ? hmean_r - AW'(prod_r)
                                              : AW'(prod_r) - hmean_r;
          state_r <= S_SQRT;
        end
        S_SQRT: state_r <= S_WAITS;
        S_WAITS: if (ds_done) begin
          out_valid_r  <= 1'b1;
          out_pos_r    <= pos_r;
          out_div_r    <= (gap_mag > 18'd65535) ? 16'hFFFF : gap_mag[15:0];
          out_status_r <= wat_pkg::ST_OK;
          state_r      <= S_IDLE;
        end
        S_OUT: begin
          out_valid_r  <= 1'b1;
          out_pos_r    <= '0;
          out_div_r    <= '0;
          out_status_r <= status_r;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `WAT_ASSERT(a_strobe_single, clk, rst_n, out_valid_r |=> !out_valid_r)
  `WAT_NEVER(a_pairs_bound, clk, rst_n, pairs_r > 3'd6)
  `WAT_ASSERT(a_unit_latency, clk, rst_n, ds_req.start |=> !ds_done)
endmodule
`default_nettype wire

@@ dv/wat_checker.sv @@
// Scoreboard for the wall anchor trilateration block: watches the input,
// config and result channels, predicts each scan result and compares it.
// Depends on wat_pkg.
`default_nettype none
module wat_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [15:0] in_range_mm,
  input  wire logic        in_last,
  input  wire logic [15:0] in_wall_distance_mm,
  input  wire logic [15:0] in_altitude_mm,
  input  wire logic        out_valid,
  input  wire logic [17:0] out_position_mm,
  input  wire logic [15:0] out_divergence_mm,
  input  wire logic [1:0]  out_status,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               errors,
  output int               pending
);
  localparam int  N_ANCHORS   = 4;
  localparam longint MIN_SPACE = 1000;

  typedef struct {
    logic [17:0]      position;
    logic [15:0]      divergence;
    wat_pkg::status_t status;
  } fix_t;

  fix_t        fix_q[$];
  logic [15:0] anchor_pos[4];
  logic [15:0] wall_offset;
  logic [15:0] scan_ranges[4];
  int          scan_len;
  bit          scan_overflow;

  function automatic longint floor_root(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // solve all anchor pairs of the closed scan
  function automatic fix_t solve_scan(logic [15:0] wall, logic [15:0] alt);
    fix_t   f;
    longint a, b, c, s, mag, q, pi, pos_sum, hsq_sum, pairs, hmean, flr, f2, diff, gap;
    f.position = '0;
    f.divergence = '0;
    f.status = wat_pkg::ST_OK;
    pos_sum = 0;
    hsq_sum = 0;
    pairs = 0;
    if (scan_overflow || scan_len != N_ANCHORS) begin
      f.status = wat_pkg::ST_COUNT;
      return f;
    end
    for (int i = 0; i < N_ANCHORS - 1; i++) begin
      for (int j = i + 1; j < N_ANCHORS; j++) begin
        a = longint'(scan_ranges[i]);
        b = longint'(scan_ranges[j]);
        pi = longint'(anchor_pos[i]);
        c = pi - longint'(anchor_pos[j]);
        if (c < 0) c = -c;
        if (a == 0 || b == 0 || c < MIN_SPACE) continue;
        if (a + c < b || b + c < a || a + b < c) continue;
        s = a * a + c * c - b * b;
        mag = (s < 0) ? -s : s;
        q = mag / (2 * c);
        if (q > a) q = a;
        hsq_sum += a * a - q * q;
        pos_sum += (s < 0) ? pi - q : pi + q;
        pairs++;
      end
    end
    if (pairs == 0) begin
      f.status = wat_pkg::ST_NO_PAIR;
      return f;
    end
    hmean = hsq_sum / pairs;
    flr = longint'(wall) - longint'(wall_offset);
    f2 = flr * flr;
    diff = (hmean >= f2) ? hmean - f2 : f2 - hmean;
    gap = floor_root(diff) - longint'(alt);
    if (gap < 0) gap = -gap;
    if (gap > 65535) gap = 65535;
    f.divergence = gap[15:0];
    f.position = 18'(pos_sum / pairs);
    return f;
  endfunction

  always_ff @(posedge clk) begin
    fix_t want;
    if (!rst_n) begin
      fix_q.delete();
      foreach (anchor_pos[k]) anchor_pos[k] <= '0;
      wall_offset <= 16'd1000;
      scan_len = 0;
      scan_overflow = 1'b0;
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (fix_q.size() == 0) begin
          $error("result beat with nothing expected: pos %0d div %0d status %0d",
                 $signed(out_position_mm), out_divergence_mm, out_status);
          errors <= errors + 1;
        end else begin
          want = fix_q.pop_front();
          if (out_position_mm !== want.position) begin
            $error("position_mm: expected %0d, got %0d",
                   $signed(want.position), $signed(out_position_mm));
            errors <= errors + 1;
          end
          if (out_divergence_mm !== want.divergence) begin
            $error("divergence_mm: expected %0d, got %0d", want.divergence,
                   out_divergence_mm);
            errors <= errors + 1;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wat_pkg::REG_POS0:   anchor_pos[0] <= cfg_data;
          wat_pkg::REG_POS1:   anchor_pos[1] <= cfg_data;
          wat_pkg::REG_POS2:   anchor_pos[2] <= cfg_data;
          wat_pkg::REG_POS3:   anchor_pos[3] <= cfg_data;
          wat_pkg::REG_OFFSET: wall_offset <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (scan_len < N_ANCHORS) scan_ranges[scan_len] = in_range_mm;
        if (scan_len < N_ANCHORS) scan_len = scan_len + 1;
        else scan_overflow = 1'b1;
        if (in_last) begin
          fix_q.insert(fix_q.size(), solve_scan(in_wall_distance_mm, in_altitude_mm));
          scan_len = 0;
          scan_overflow = 1'b0;
        end
      end
      pending <= fix_q.size();
    end
  end
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench top for wall_anchor_trilateration_unit: drives scans and config
// writes, instantiates the block and wat_checker, and gives the verdict.
// Depends on wat_pkg, wat_checker and the block RTL.
`default_nettype none
module tb_top;
  localparam int DRAIN_CYCLES = 450;
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_range_mm = '0;
  logic        in_last = 1'b0;
  logic [15:0] in_wall_distance_mm = '0;
  logic [15:0] in_altitude_mm = '0;
  logic        out_valid;
  logic signed [wat_pkg::POS_W-1:0] out_position_mm;
  logic [15:0] out_divergence_mm;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          beats_sent;
  int          idle_cycles;
  bit          quiet_phase;
  logic [15:0] cur_pos[4];
  logic [15:0] cur_offset;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wall_anchor_trilateration_unit dut (
    .clk, .rst_n, .start, .busy, .in_range_mm, .in_last, .in_wall_distance_mm,
    .in_altitude_mm, .out_valid, .out_position_mm, .out_divergence_mm,
    .out_status, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  wat_checker chk (
    .clk, .rst_n, .start, .busy, .in_range_mm, .in_last, .in_wall_distance_mm,
    .in_altitude_mm, .out_valid, .out_position_mm, .out_divergence_mm,
    .out_status, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  // watchdog on cycles where no beat moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic random_gap();
    int roll, n;
    roll = $urandom_range(0, 99);
    if (quiet_phase || roll < 60) n = 0;
    else if (roll < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(20, 200);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one input beat; busy is sampled at the falling edge before each rising edge
  task automatic send_beat(logic [15:0] rng, logic lst, logic [15:0] wall,
                           logic [15:0] alt);
    logic b;
    start <= 1'b1;
    in_range_mm <= rng;
    in_last <= lst;
    in_wall_distance_mm <= wall;
    in_altitude_mm <= alt;
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
    beats_sent++;
    random_gap();
  endtask

  // valid stays high after the beat; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    logic r;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
    if (idx == wat_pkg::REG_OFFSET) cur_offset = val;
    else if (idx < 4) cur_pos[idx] = val;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_anchors(logic [15:0] p0, logic [15:0] p1, logic [15:0] p2,
                             logic [15:0] p3, logic [15:0] off);
    wait_idle();
    write_reg(wat_pkg::REG_POS0, p0);
    write_reg(wat_pkg::REG_POS1, p1);
    write_reg(wat_pkg::REG_POS2, p2);
    write_reg(wat_pkg::REG_POS3, p3);
    write_reg(wat_pkg::REG_OFFSET, off);
    write_reg(3'd5 + 3'($urandom_range(0, 2)), 16'($urandom));  // dropped index
    cfg_valid <= 1'b0;
  endtask

  // ranges from a point at x along the wall and height h, with a little noise
  task automatic geometric_scan();
    int  x, h, r;
    real d;
    x = $urandom_range(0, 70000) - 2000;
    h = $urandom_range(0, 30000);
    for (int k = 0; k < 4; k++) begin
      d = real'(x - int'(cur_pos[k]));
      r = $rtoi($sqrt(d * d + real'(h) * real'(h))) + $urandom_range(0, 6) - 3;
      if (r < 1) r = 1;
      if (r > 65535) r = 65535;
      if ($urandom_range(0, 19) == 0) r = 0;
      send_beat(16'(r), k == 3, 16'(int'(cur_offset) + $urandom_range(0, 4000)),
                16'($urandom));
    end
  endtask

  task automatic noise_scan();
    int len;
    len = $urandom_range(1, 7);
    for (int k = 0; k < len; k++)
      send_beat(16'($urandom), k == len - 1, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_phase(int items);
    int goal;
    goal = beats_sent + items;
    quiet_phase = $urandom_range(0, 1);
    while (beats_sent < goal) begin
      if ($urandom_range(0, 99) < 80) geometric_scan();
      else noise_scan();
      quiet_phase = ($urandom_range(0, 9) == 0) ? !quiet_phase : quiet_phase;
    end
  endtask

  initial begin
    beats_sent = 0;
    quiet_phase = 1'b0;
    cur_pos = '{default: '0};
    cur_offset = 16'd1000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default registers give no spaced pair
    send_beat(16'd1500, 1'b0, 16'd0, 16'd0);
    send_beat(16'd1500, 1'b0, 16'd0, 16'd0);
    send_beat(16'd1500, 1'b0, 16'd0, 16'd0);
    send_beat(16'd1500, 1'b1, 16'd65535, 16'd65535);
    set_anchors(16'd0, 16'd3000, 16'd6000, 16'd9000, 16'd1000);
    send_beat(16'd5000, 1'b0, 16'd0, 16'd0);   // clean geometry
    send_beat(16'd4000, 1'b0, 16'd0, 16'd0);
    send_beat(16'd5000, 1'b0, 16'd0, 16'd0);
    send_beat(16'd7000, 1'b1, 16'd1000, 16'd3000);
    send_beat(16'd0, 1'b0, 16'd0, 16'd0);      // zero range, short scan
    send_beat(16'd65535, 1'b1, 16'd65535, 16'd0);
    for (int k = 0; k < 6; k++)                // too many ranges
      send_beat(16'd4000, k == 5, 16'd2000, 16'd100);
    send_beat(16'd1, 1'b0, 16'd0, 16'd0);      // only anchors 1 and 3 close a triangle
    send_beat(16'd65535, 1'b0, 16'd0, 16'd0);
    send_beat(16'd1, 1'b0, 16'd0, 16'd0);
    send_beat(16'd65535, 1'b1, 16'd0, 16'd65535);
    send_beat(16'd65535, 1'b0, 16'd0, 16'd0);  // all ranges at max
    send_beat(16'd65535, 1'b0, 16'd0, 16'd0);
    send_beat(16'd65535, 1'b0, 16'd0, 16'd0);
    send_beat(16'd65535, 1'b1, 16'd65535, 16'd0);

    random_phase(RANDOM_ITEMS / 5);
    wait_idle();                                // sender holds off until drained
    random_phase(RANDOM_ITEMS / 10);
    set_anchors(16'd0, 16'd65535, 16'd1000, 16'd64535, 16'd65535);
    random_phase(RANDOM_ITEMS / 5);
    set_anchors(16'd65535, 16'd0, 16'd32768, 16'd999, 16'd0);
    random_phase(RANDOM_ITEMS / 5);
    set_anchors(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    random_phase(RANDOM_ITEMS / 10);
    set_anchors(16'd0, 16'd0, 16'd0, 16'd0, 16'd1000);
    random_phase(RANDOM_ITEMS / 20);
    set_anchors(16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'd500);
    random_phase(RANDOM_ITEMS / 5);

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
